### rtl/core/rfhb_pkg.sv
// Shared types, widths, register indexes and band tables for the height bander.
`default_nettype none

package rfhb_pkg;

  localparam int COORD_W     = 10;
  localparam int HEIGHT_W    = 8;
  localparam int GAIN_W      = 19;
  localparam int BAND_W      = 3;
  localparam int COLOR_W     = 8;
  localparam int SQRT_FRAC_W = 8;
  localparam int Q_FRAC      = 32;
  localparam int NUM_BANDS   = 8;
  localparam int NUM_LIMITS  = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_WATER_LEVEL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_GAIN = 1'd1;

  localparam logic [HEIGHT_W-1:0] WATER_LEVEL_RST  = 8'd100;
  localparam logic [GAIN_W-1:0]   FALLOFF_GAIN_RST = 19'd46341;

  localparam logic [HEIGHT_W-1:0] BAND_OFFSET [NUM_LIMITS] = '{
    8'd0, 8'd10, 8'd12, 8'd14, 8'd25, 8'd55, 8'd80
  };

  localparam logic [3*COLOR_W-1:0] BAND_RGB [NUM_BANDS] = '{
    24'h4169E1,
    24'h5899ED,
    24'hEED6AF,
    24'hD2B48C,
    24'h228B22,
    24'h006400,
    24'h8B8989,
    24'hFFFAFA
  };

  typedef struct packed {
    logic [HEIGHT_W-1:0] water_level;
    logic [GAIN_W-1:0]   falloff_gain;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/rfhb_dist.sv
// Three-stage pipeline forming the squared distance of a pixel from the image center.
`default_nettype none

module rfhb_dist import rfhb_pkg::*; #(
  parameter int IMAGE_SIZE = 1024,
  parameter int DW         = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [COORD_W-1:0]  in_pixel_x,
  input  wire logic [COORD_W-1:0]  in_pixel_y,
  input  wire logic [HEIGHT_W-1:0] in_noise_height,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2*DW:0]            out_sum,
  output logic [HEIGHT_W-1:0]      out_height
);

  localparam int SW = 2*DW + 1;
  localparam logic [DW-1:0] CENTER = DW'(IMAGE_SIZE / 2);

  logic                v1_r, v2_r, v3_r;
  logic                rdy1, rdy2, rdy3;
  logic [DW-1:0]       px_e, py_e;
  logic [DW-1:0]       dx_nxt, dy_nxt;
  logic [DW-1:0]       dx_r, dy_r;
  logic [2*DW-1:0]     sqx_r, sqy_r;
  logic [SW-1:0]       sum_r;
  logic [HEIGHT_W-1:0] h1_r, h2_r, h3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign px_e   = DW'(in_pixel_x);
  assign py_e   = DW'(in_pixel_y);
  assign dx_nxt = (px_e > CENTER) ? (px_e - CENTER) : (CENTER - px_e);
  assign dy_nxt = (py_e > CENTER) ? (py_e - CENTER) : (CENTER - py_e);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      h1_r <= in_noise_height;
    end
    if (rdy2 && v1_r) begin
      sqx_r <= (2*DW)'(dx_r) * (2*DW)'(dx_r);
      sqy_r <= (2*DW)'(dy_r) * (2*DW)'(dy_r);
      h2_r  <= h1_r;
    end
    if (rdy3 && v2_r) begin
      sum_r <= SW'(sqx_r) + SW'(sqy_r);
      h3_r  <= h2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_sum    = sum_r;
  assign out_height = h3_r;

endmodule

`default_nettype wire

### rtl/core/rfhb_sqrt.sv
// Pipelined square root, one result bit per stage, giving the distance with eight fraction bits.
`default_nettype none

module rfhb_sqrt import rfhb_pkg::*; #(
  parameter int SUM_W = 21
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SUM_W-1:0]    in_sum,
  input  wire logic [HEIGHT_W-1:0] in_height,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [(SUM_W+2*SQRT_FRAC_W+1)/2-1:0] out_root,
  output logic [HEIGHT_W-1:0]      out_height
);

  localparam int RAD_W  = SUM_W + 2*SQRT_FRAC_W;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2*ROOT_W;

  logic [ROOT_W-1:0]   v_r;
  logic [ROOT_W:0]     rdy;
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [ROOT_W:0]     rem_r  [ROOT_W-1];
  logic [PAD_W-1:0]    rad_r  [ROOT_W-1];
  logic [HEIGHT_W-1:0] h_r    [ROOT_W];
  logic [PAD_W-1:0]    rad_in;

  assign rad_in       = PAD_W'({in_sum, {(2*SQRT_FRAC_W){1'b0}}});
  assign rdy[ROOT_W]  = out_ready;
  assign in_ready     = rdy[0];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                vin;
    logic [ROOT_W-1:0]   root_src;
    logic [ROOT_W:0]     rem_src;
    logic [PAD_W-1:0]    rad_src;
    logic [HEIGHT_W-1:0] h_src;
    logic [ROOT_W+2:0]   cur;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;
    logic                take;

    if (k == 0) begin : g_first
      assign vin      = in_valid;
      assign root_src = '0;
      assign rem_src  = '0;
      assign rad_src  = rad_in;
      assign h_src    = in_height;
    end else begin : g_next
      assign vin      = v_r[k-1];
      assign root_src = root_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign rad_src  = rad_r[k-1];
      assign h_src    = h_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];
    assign cur    = {rem_src, rad_src[PAD_W-1 -: 2]};
    assign trial  = (ROOT_W+3)'({root_src, 2'b01});
    assign take   = cur >= trial;
    assign diff   = cur - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin) begin
        root_r[k] <= {root_src[ROOT_W-2:0], take};
        h_r[k]    <= h_src;
      end
    end

    if (k < ROOT_W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (rdy[k] && vin) begin
          rem_r[k] <= take ? diff[ROOT_W:0] : cur[ROOT_W:0];
          rad_r[k] <= {rad_src[PAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid  = v_r[ROOT_W-1];
  assign out_root   = root_r[ROOT_W-1];
  assign out_height = h_r[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/core/rfhb_shade.sv
// Three-stage pipeline applying the falloff to the height and picking the band and its color.
`default_nettype none

module rfhb_shade import rfhb_pkg::*; #(
  parameter int ROOT_W = 19
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ROOT_W-1:0]   in_root,
  input  wire logic [HEIGHT_W-1:0] in_height,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [HEIGHT_W-1:0]      out_shaded_height,
  output logic                     out_is_water,
  output logic [BAND_W-1:0]        out_band,
  output logic [COLOR_W-1:0]       out_red,
  output logic [COLOR_W-1:0]       out_green,
  output logic [COLOR_W-1:0]       out_blue_level
);

  localparam int P_W    = ROOT_W + GAIN_W;
  localparam int F_W    = Q_FRAC + 1;
  localparam int PROD_W = HEIGHT_W + F_W;

  logic                 v1_r, v2_r, v3_r;
  logic                 rdy1, rdy2, rdy3;
  logic [P_W-1:0]       p_r;
  logic [HEIGHT_W-1:0]  h1_r;
  logic [HEIGHT_W-1:0]  s_r;
  logic                 over;
  logic [F_W-1:0]       factor;
  logic [PROD_W-1:0]    prod;
  logic [HEIGHT_W-1:0]  s_nxt;
  logic [BAND_W-1:0]    band_nxt;
  logic [3*COLOR_W-1:0] rgb_nxt;
  logic [HEIGHT_W-1:0]  shaded_r;
  logic                 water_r;
  logic [BAND_W-1:0]    band_r;
  logic [3*COLOR_W-1:0] rgb_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign over   = |p_r[P_W-1:Q_FRAC];
  assign factor = {1'b1, {Q_FRAC{1'b0}}} - {1'b0, p_r[Q_FRAC-1:0]};
  assign prod   = PROD_W'(h1_r) * PROD_W'(factor);
  assign s_nxt  = over ? '0 : prod[Q_FRAC +: HEIGHT_W];

  always_comb begin
    logic [HEIGHT_W:0] lim;
    band_nxt = '0;
    for (int k = 0; k < NUM_LIMITS; k++) begin
      lim = {1'b0, cfg.water_level} + {1'b0, BAND_OFFSET[k]};
      if ({1'b0, s_r} >= lim) band_nxt = band_nxt + 1'b1;
    end
    rgb_nxt = BAND_RGB[band_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      p_r  <= P_W'(in_root) * P_W'(cfg.falloff_gain);
      h1_r <= in_height;
    end
    if (rdy2 && v1_r) begin
      s_r <= s_nxt;
    end
    if (rdy3 && v2_r) begin
      shaded_r <= s_r;
      water_r  <= s_r < cfg.water_level;
      band_r   <= band_nxt;
      rgb_r    <= rgb_nxt;
    end
  end

  assign out_valid         = v3_r;
  assign out_shaded_height = shaded_r;
  assign out_is_water      = water_r;
  assign out_band          = band_r;
  assign out_red           = rgb_r[3*COLOR_W-1 -: COLOR_W];
  assign out_green         = rgb_r[2*COLOR_W-1 -: COLOR_W];
  assign out_blue_level    = rgb_r[COLOR_W-1:0];

endmodule

`default_nettype wire

### rtl/core/radial_falloff_height_bander.sv
// Top level of the radial falloff height bander: configuration registers and pipeline.
//
// Pixels enter on the in_ channel as one beat each (x, y and a noise height) and
// leave on the out_ channel as one beat each: shaded height, water flag, band and
// band color, in the order they entered. Both channels use valid and ready.
// The pipeline takes one beat per cycle unless a stalled receiver holds it back.
// The square root has R stages, one per root bit: R = (2*D + 17 + 1) / 2 with D
// the width of a coordinate offset, max(10, clog2(IMAGE_SIZE/2 + 1)).
// Every stage holds its beat while the next stage is full and held, so a stalled receiver
// backs up the pipeline one stage at a time and empty stages keep filling; no
// beat is lost or repeated.
// The cfg_ port writes the water level (index 0) or falloff_gain (index 1);
// write only while no beat is inside the pipeline.
// Synchronous reset empties the pipeline and restores the water level to 100 and
// falloff_gain to 46341.
`default_nettype none

module radial_falloff_height_bander import rfhb_pkg::*; #(
  parameter int IMAGE_SIZE = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_W-1:0]    in_pixel_x,
  input  wire logic [COORD_W-1:0]    in_pixel_y,
  input  wire logic [HEIGHT_W-1:0]   in_noise_height,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [HEIGHT_W-1:0]        out_shaded_height,
  output logic                       out_is_water,
  output logic [BAND_W-1:0]          out_band,
  output logic [COLOR_W-1:0]         out_red,
  output logic [COLOR_W-1:0]         out_green,
  output logic [COLOR_W-1:0]         out_blue_level
);

  localparam int CW     = $clog2(IMAGE_SIZE / 2 + 1);
  localparam int DW     = (CW > COORD_W) ? CW : COORD_W;
  localparam int SW     = 2*DW + 1;
  localparam int ROOT_W = (SW + 2*SQRT_FRAC_W + 1) / 2;

  logic [HEIGHT_W-1:0] land_r, land_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  cfg_t                cfg;

  logic                dist_valid, dist_ready;
  logic [SW-1:0]       dist_sum;
  logic [HEIGHT_W-1:0] dist_height;
  logic                root_valid, root_ready;
  logic [ROOT_W-1:0]   root_val;
  logic [HEIGHT_W-1:0] root_height;

  always_comb begin
    land_nxt = land_r;
    gain_nxt = gain_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WATER_LEVEL:  land_nxt = cfg_wdata[HEIGHT_W-1:0];
        REG_FALLOFF_GAIN: gain_nxt = cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      land_r <= WATER_LEVEL_RST;
      gain_r <= FALLOFF_GAIN_RST;
    end else begin
      land_r <= land_nxt;
      gain_r <= gain_nxt;
    end
  end

  assign cfg.water_level  = land_r;
  assign cfg.falloff_gain = gain_r;

  rfhb_dist #(
    .IMAGE_SIZE (IMAGE_SIZE),
    .DW         (DW)
  ) u_dist (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_noise_height (in_noise_height),
    .out_valid       (dist_valid),
    .out_ready       (dist_ready),
    .out_sum         (dist_sum),
    .out_height      (dist_height)
  );

  rfhb_sqrt #(
    .SUM_W (SW)
  ) u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dist_valid),
    .in_ready   (dist_ready),
    .in_sum     (dist_sum),
    .in_height  (dist_height),
    .out_valid  (root_valid),
    .out_ready  (root_ready),
    .out_root   (root_val),
    .out_height (root_height)
  );

  rfhb_shade #(
    .ROOT_W (ROOT_W)
  ) u_shade (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (root_valid),
    .in_ready          (root_ready),
    .in_root           (root_val),
    .in_height         (root_height),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_shaded_height (out_shaded_height),
    .out_is_water      (out_is_water),
    .out_band          (out_band),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue_level    (out_blue_level)
  );

endmodule

`default_nettype wire
